// ----- sv/grs_pkg.sv -----
package grs_pkg;

  localparam int LANES               = 8;
  localparam int LANE_SH             = 3;
  localparam int GENO_W              = 2;
  localparam int ROW_W               = LANES * GENO_W;
  localparam int SCALED_W            = 16;
  localparam int MF_W                = 16;
  localparam int CNT_W               = 10;
  localparam int SUM_W               = 11;
  localparam int DEN_W               = 11;
  localparam int NUM_W               = 12;
  localparam int MAG_W               = 11;
  localparam int DV_W                = 19;
  localparam int PROD_W              = 24;
  localparam int Q4_W                = 41;
  localparam int TSQ_W               = 32;
  localparam int ROOT_W              = 16;
  localparam int BIT_W               = 4;
  localparam int DVD_W               = 27;
  localparam int DVS_W               = 12;
  localparam int DCNT_W              = 5;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 16;
  localparam int MAX_INDIVIDUALS_DEF = 512;

  localparam logic [GENO_W-1:0]    MISSING_CODE = 2'd3;
  localparam logic [ROOT_W-1:0]    ROOT_CAP     = 16'd32768;
  localparam logic [ROOT_W-1:0]    POS_MAX      = 16'd32767;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_IND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIPLOID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAF  = 2'd2;
  localparam logic [1:0]           XI_LAST      = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM,
    ST_CALC_A,
    ST_CALC_B,
    ST_CALC_C,
    ST_DIV,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } grs_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef struct packed {
    logic [GENO_W-1:0] geno_a;
    logic [GENO_W-1:0] geno_b;
    logic [GENO_W-1:0] geno_c;
    logic [GENO_W-1:0] geno_d;
    logic [GENO_W-1:0] geno_e;
    logic [GENO_W-1:0] geno_f;
    logic [GENO_W-1:0] geno_g;
    logic [GENO_W-1:0] geno_h;
  } geno_word_t;

  typedef struct packed {
    logic signed [SCALED_W-1:0] scaled_a;
    logic signed [SCALED_W-1:0] scaled_b;
    logic signed [SCALED_W-1:0] scaled_c;
    logic signed [SCALED_W-1:0] scaled_d;
    logic signed [SCALED_W-1:0] scaled_e;
    logic signed [SCALED_W-1:0] scaled_f;
    logic signed [SCALED_W-1:0] scaled_g;
    logic signed [SCALED_W-1:0] scaled_h;
    logic [MF_W-1:0]            minor_freq;
    logic [CNT_W-1:0]           missing_count;
    logic                       row_all_missing;
    logic                       last_of_row;
  } result_word_t;

endpackage

// ----- sv/grs_row_mem.sv -----
module grs_row_mem #(
  parameter int ROWS = 64,
  parameter int AW   = 6
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [grs_pkg::ROW_W-1:0]  wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [grs_pkg::ROW_W-1:0]  rd_data_o
);

  logic [grs_pkg::ROW_W-1:0] mem_q [ROWS];
  logic [grs_pkg::ROW_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- sv/grs_div.sv -----
module grs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grs_pkg::DVD_W-1:0]     dividend_i,
  input  logic [grs_pkg::DVS_W-1:0]     divisor_i,
  output grs_pkg::unit_status_t         status_o,
  output logic [grs_pkg::MF_W-1:0]      quotient_o
);

  logic                        busy_q, done_q;
  logic [grs_pkg::DCNT_W-1:0]  cnt_q;
  logic [grs_pkg::DVD_W-1:0]   dvd_q;
  logic [grs_pkg::DVS_W-1:0]   rem_q, dvs_q, rem_d;
  logic [grs_pkg::MF_W-1:0]    quo_q;
  logic [grs_pkg::DVS_W:0]     trial, diff;
  logic                        ge;

  always_comb begin
    trial = {rem_q, dvd_q[grs_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[grs_pkg::DVS_W-1:0] : trial[grs_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= grs_pkg::DCNT_W'(grs_pkg::DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == grs_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[grs_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[grs_pkg::MF_W-2:0], ge};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

// ----- sv/grs_scale.sv -----
module grs_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [grs_pkg::MAG_W-1:0]     mag_i,
  input  logic                          diploid_i,
  input  logic [grs_pkg::DV_W-1:0]      d_i,
  output grs_pkg::unit_status_t         status_o,
  output logic [grs_pkg::ROOT_W-1:0]    root_o
);

  logic                         busy_q, done_q, phase_q;
  logic [grs_pkg::BIT_W-1:0]    bit_q;
  logic [grs_pkg::Q4_W-1:0]     q4_q, q4_d;
  logic [grs_pkg::DV_W-1:0]     d_q;
  logic [grs_pkg::ROOT_W-1:0]   r_q, cand;
  logic [grs_pkg::TSQ_W-1:0]    tsq_q;
  logic [grs_pkg::ROOT_W:0]     t_full;
  logic [2*grs_pkg::MAG_W-1:0]  msq;
  logic [grs_pkg::TSQ_W+grs_pkg::DV_W-1:0] prod;
  logic                         cand_ok, last_bit;

  always_comb begin
    msq      = (2*grs_pkg::MAG_W)'(mag_i) * (2*grs_pkg::MAG_W)'(mag_i);
    q4_d     = (grs_pkg::Q4_W'(msq) << 18) << diploid_i;
    cand     = r_q | (grs_pkg::ROOT_W'(1) << bit_q);
    cand_ok  = cand <= grs_pkg::ROOT_CAP;
    t_full   = {cand, 1'b0} - (grs_pkg::ROOT_W+1)'(1);
    prod     = (grs_pkg::TSQ_W+grs_pkg::DV_W)'(tsq_q) *
               (grs_pkg::TSQ_W+grs_pkg::DV_W)'(d_q);
    last_bit = bit_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        bit_q   <= '1;
      end else if (busy_q) begin
        if (!phase_q && cand_ok) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          bit_q   <= bit_q - 1'b1;
          if (last_bit) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q4_q <= q4_d;
      d_q  <= d_i;
      r_q  <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        tsq_q <= t_full[grs_pkg::ROOT_W-1:0] * t_full[grs_pkg::ROOT_W-1:0];
      end else if ((grs_pkg::TSQ_W+grs_pkg::DV_W)'(q4_q) >= prod) begin
        r_q <= cand;
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign root_o        = r_q;

endmodule

// ----- sv/genotype_row_standardize_core.sv -----
// Genotype row standardizer.
// Input words carry eight 2-bit genotype codes (3 = missing); lane l of
// word k is individual 8k+l. A row is ceil(n/8) words, n = num_individuals
// clamped to 1..MAX_INDIVIDUALS. Words load into the row memory at one per
// cycle while the input is not stalled. After the last word of a row the
// block stalls its input while it sweeps the row memory, computes the row
// statistics, divides for the minor frequency (when the row is not all
// missing and the numerator is nonzero), runs the square-root search for
// each of the three codes when scaling is needed, then drains the result
// words, one per stored input word. The divider and root search are
// bit-serial.
// Results sit in an output register: a stalled result holds, and loading of
// the next row proceeds while the last result of a row still waits.
// The config port always accepts; write it only while the block is idle.
// Reset clears the control state and restores the register defaults.
module genotype_row_standardize_core #(
  parameter int MAX_INDIVIDUALS = grs_pkg::MAX_INDIVIDUALS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  grs_pkg::geno_word_t               in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output grs_pkg::result_word_t             out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [grs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [grs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int ROWS = (MAX_INDIVIDUALS + grs_pkg::LANES - 1) / grs_pkg::LANES;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW   = $clog2(ROWS + 1);
  localparam int NW   = $clog2(MAX_INDIVIDUALS + 1);

  grs_pkg::grs_state_e state_q, state_d;

  logic [grs_pkg::CNT_W-1:0]   nind_q;
  logic                        dip_q;
  logic [grs_pkg::MF_W-1:0]    mmf_q;

  logic [NW-1:0]               n_eff;
  logic [NW:0]                 n_pad;
  logic [RW-1:0]               need, cnt_q, ptr_q, rrow_q;
  logic                        rv_q;
  logic                        row_done, issue_more, sum_last, ptr_last;

  logic [grs_pkg::SUM_W-1:0]   s_q;
  logic [grs_pkg::CNT_W-1:0]   m_q, c_q;
  logic [grs_pkg::DEN_W-1:0]   den_q;
  logic                        all_miss_q, pass_q, d_pos_q, num_pos;
  logic signed [grs_pkg::NUM_W-1:0] num_q, num_d;
  logic [grs_pkg::DV_W-1:0]    d_q;
  logic signed [grs_pkg::PROD_W-1:0] d_full;
  logic [grs_pkg::MF_W-1:0]    mf_q;
  logic [1:0]                  xi_q;
  logic [grs_pkg::SCALED_W-1:0] sv0_q, sv1_q, sv2_q, sv_new;

  logic [grs_pkg::ROW_W-1:0]   wr_data, rd_data;
  logic [grs_pkg::GENO_W-1:0]  lane_in [grs_pkg::LANES];
  logic [4:0]                  row_sum;
  logic [3:0]                  row_miss;

  logic                        in_acc, rd_en, div_start, scale_start, out_load, scale_need;
  grs_pkg::unit_status_t       div_st, scale_st;
  logic [grs_pkg::MF_W-1:0]    div_quo;
  logic [grs_pkg::ROOT_W-1:0]  root;
  logic signed [grs_pkg::NUM_W:0] a_val;
  logic [grs_pkg::MAG_W-1:0]   a_mag;
  logic [grs_pkg::DVD_W-1:0]   dividend;

  logic                        out_valid_q;
  grs_pkg::result_word_t       out_q, out_d;
  logic signed [grs_pkg::SCALED_W-1:0] lv [grs_pkg::LANES];

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nind_q <= grs_pkg::CNT_W'(512);
      dip_q  <= 1'b1;
      mmf_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        grs_pkg::CFG_NUM_IND: nind_q <= cfg_data_i[grs_pkg::CNT_W-1:0];
        grs_pkg::CFG_DIPLOID: dip_q <= cfg_data_i[0];
        grs_pkg::CFG_MIN_MAF: mmf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (nind_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(nind_q) > 32'(MAX_INDIVIDUALS)) begin
      n_eff = NW'(MAX_INDIVIDUALS);
    end else begin
      n_eff = NW'(nind_q);
    end
    n_pad      = (NW+1)'(n_eff) + (NW+1)'(grs_pkg::LANES - 1);
    need       = RW'(n_pad >> grs_pkg::LANE_SH);
    row_done   = ((RW+1)'(cnt_q) + (RW+1)'(1)) >= (RW+1)'(need);
    issue_more = ptr_q < need;
    sum_last   = rv_q && ((RW+1)'(rrow_q) + (RW+1)'(1) == (RW+1)'(need));
    ptr_last   = (RW+1)'(ptr_q) + (RW+1)'(1) == (RW+1)'(need);
  end

  assign lane_in[0] = in_word_i.geno_a;
  assign lane_in[1] = in_word_i.geno_b;
  assign lane_in[2] = in_word_i.geno_c;
  assign lane_in[3] = in_word_i.geno_d;
  assign lane_in[4] = in_word_i.geno_e;
  assign lane_in[5] = in_word_i.geno_f;
  assign lane_in[6] = in_word_i.geno_g;
  assign lane_in[7] = in_word_i.geno_h;

  always_comb begin
    for (int l = 0; l < grs_pkg::LANES; l++) begin
      wr_data[l*grs_pkg::GENO_W +: grs_pkg::GENO_W] = lane_in[l];
    end
  end

  grs_row_mem #(.ROWS(ROWS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // per-row partial sums during the sweep
  always_comb begin
    logic [grs_pkg::GENO_W-1:0] code;
    row_sum  = '0;
    row_miss = '0;
    for (int l = 0; l < grs_pkg::LANES; l++) begin
      code = rd_data[l*grs_pkg::GENO_W +: grs_pkg::GENO_W];
      if (32'({rrow_q, grs_pkg::LANE_SH'(l)}) < 32'(n_eff)) begin
        if (code == grs_pkg::MISSING_CODE) begin
          row_miss = row_miss + 4'd1;
        end else begin
          row_sum = row_sum + 5'(code);
        end
      end
    end
  end

  // statistics
  always_comb begin
    if ({s_q, 1'b0} <= {1'b0, den_q}) begin
      num_d = $signed(grs_pkg::NUM_W'(s_q));
    end else begin
      num_d = $signed(grs_pkg::NUM_W'(den_q)) - $signed(grs_pkg::NUM_W'(s_q));
    end
    d_full  = $signed(grs_pkg::PROD_W'(s_q)) *
              ($signed(grs_pkg::PROD_W'(den_q)) - $signed(grs_pkg::PROD_W'(s_q)));
    num_pos = num_q > 0;
    dividend = (grs_pkg::DVD_W'(num_q[grs_pkg::NUM_W-2:0]) << 17) + grs_pkg::DVD_W'(den_q);
    scale_need = !all_miss_q && pass_q && d_pos_q;
    a_val = $signed((grs_pkg::NUM_W+1)'(xi_q) * (grs_pkg::NUM_W+1)'(c_q)) -
            $signed((grs_pkg::NUM_W+1)'(s_q));
    a_mag = a_val[grs_pkg::NUM_W] ? grs_pkg::MAG_W'(-a_val) : grs_pkg::MAG_W'(a_val);
    if (a_val[grs_pkg::NUM_W]) begin
      sv_new = grs_pkg::SCALED_W'(17'd65536 - 17'(root));
    end else if (root > grs_pkg::POS_MAX) begin
      sv_new = grs_pkg::POS_MAX;
    end else begin
      sv_new = root;
    end
  end

  grs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  ({den_q, 1'b0}),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  grs_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scale_start),
    .mag_i     (a_mag),
    .diploid_i (dip_q),
    .d_i       (d_q),
    .status_o  (scale_st),
    .root_o    (root)
  );

  // FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    scale_start = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      grs_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i && row_done) begin
          state_d = grs_pkg::ST_SUM;
        end
      end
      grs_pkg::ST_SUM: begin
        rd_en = issue_more;
        if (sum_last) begin
          state_d = grs_pkg::ST_CALC_A;
        end
      end
      grs_pkg::ST_CALC_A: state_d = grs_pkg::ST_CALC_B;
      grs_pkg::ST_CALC_B: state_d = grs_pkg::ST_CALC_C;
      grs_pkg::ST_CALC_C: begin
        if (!all_miss_q && num_pos) begin
          div_start = 1'b1;
          state_d   = grs_pkg::ST_DIV;
        end else if (scale_need) begin
          state_d = grs_pkg::ST_SCALE_GO;
        end else begin
          state_d = grs_pkg::ST_DRAIN_RD;
        end
      end
      grs_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_d = scale_need ? grs_pkg::ST_SCALE_GO : grs_pkg::ST_DRAIN_RD;
        end
      end
      grs_pkg::ST_SCALE_GO: begin
        scale_start = 1'b1;
        state_d     = grs_pkg::ST_SCALE_WAIT;
      end
      grs_pkg::ST_SCALE_WAIT: begin
        if (scale_st.done) begin
          state_d = (xi_q == grs_pkg::XI_LAST) ? grs_pkg::ST_DRAIN_RD
                                               : grs_pkg::ST_SCALE_GO;
        end
      end
      grs_pkg::ST_DRAIN_RD: begin
        rd_en   = 1'b1;
        state_d = grs_pkg::ST_DRAIN_OUT;
      end
      grs_pkg::ST_DRAIN_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ptr_last ? grs_pkg::ST_LOAD : grs_pkg::ST_DRAIN_RD;
        end
      end
      default: state_d = grs_pkg::ST_LOAD;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      rrow_q      <= '0;
      rv_q        <= 1'b0;
      xi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rv_q   <= rd_en && (state_q == grs_pkg::ST_SUM);
      rrow_q <= ptr_q;
      if (in_acc) begin
        cnt_q <= row_done ? '0 : cnt_q + 1'b1;
        ptr_q <= '0;
      end else if (state_q == grs_pkg::ST_SUM && rd_en) begin
        ptr_q <= ptr_q + 1'b1;
      end else if (state_q == grs_pkg::ST_CALC_C) begin
        ptr_q <= '0;
        xi_q  <= '0;
      end else if (state_q == grs_pkg::ST_SCALE_WAIT && scale_st.done) begin
        xi_q <= xi_q + 1'b1;
      end else if (out_load) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && row_done) begin
      s_q <= '0;
      m_q <= '0;
    end else if (rv_q) begin
      s_q <= s_q + grs_pkg::SUM_W'(row_sum);
      m_q <= m_q + grs_pkg::CNT_W'(row_miss);
    end
    if (state_q == grs_pkg::ST_CALC_A) begin
      c_q        <= grs_pkg::CNT_W'(n_eff) - m_q;
      den_q      <= dip_q ? {grs_pkg::CNT_W'(n_eff) - m_q, 1'b0}
                          : {1'b0, grs_pkg::CNT_W'(n_eff) - m_q};
      all_miss_q <= m_q == grs_pkg::CNT_W'(n_eff);
    end
    if (state_q == grs_pkg::ST_CALC_B) begin
      num_q   <= num_d;
      d_q     <= d_full[grs_pkg::DV_W-1:0];
      d_pos_q <= d_full > 0;
    end
    if (state_q == grs_pkg::ST_CALC_C) begin
      pass_q <= !num_q[grs_pkg::NUM_W-1] &&
                ((grs_pkg::DVD_W'(num_q[grs_pkg::NUM_W-2:0]) << 16) >=
                 grs_pkg::DVD_W'(mmf_q) * grs_pkg::DVD_W'(den_q));
      mf_q   <= '0;
    end
    if (state_q == grs_pkg::ST_DIV && div_st.done) begin
      mf_q <= div_quo;
    end
    if (state_q == grs_pkg::ST_SCALE_WAIT && scale_st.done) begin
      unique case (xi_q)
        2'd0:    sv0_q <= sv_new;
        2'd1:    sv1_q <= sv_new;
        default: sv2_q <= sv_new;
      endcase
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // result word
  always_comb begin
    logic [grs_pkg::GENO_W-1:0] code;
    for (int l = 0; l < grs_pkg::LANES; l++) begin
      code  = rd_data[l*grs_pkg::GENO_W +: grs_pkg::GENO_W];
      lv[l] = '0;
      if (32'({ptr_q, grs_pkg::LANE_SH'(l)}) < 32'(n_eff) && !all_miss_q && pass_q &&
          code != grs_pkg::MISSING_CODE) begin
        if (!d_pos_q) begin
          lv[l] = $signed(grs_pkg::SCALED_W'(code) << 8);
        end else begin
          unique case (code)
            2'd0:    lv[l] = $signed(sv0_q);
            2'd1:    lv[l] = $signed(sv1_q);
            default: lv[l] = $signed(sv2_q);
          endcase
        end
      end
    end
    out_d.scaled_a        = lv[0];
    out_d.scaled_b        = lv[1];
    out_d.scaled_c        = lv[2];
    out_d.scaled_d        = lv[3];
    out_d.scaled_e        = lv[4];
    out_d.scaled_f        = lv[5];
    out_d.scaled_g        = lv[6];
    out_d.scaled_h        = lv[7];
    out_d.minor_freq      = mf_q;
    out_d.missing_count   = m_q;
    out_d.row_all_missing = all_miss_q;
    out_d.last_of_row     = ptr_last;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
